// ===== sv/dps_pkg.sv =====
`timescale 1ns / 1ps
package dps_pkg;

   localparam int MAX_SAMPLES_DEF = 1024;
   localparam int SAMPLE_BITS_DEF = 32;

   // operation codes
   localparam logic OP_ADD    = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [31:0] sample;
   } req_type;

   typedef struct packed {
      logic [10:0] sample_total;
      logic [31:0] mean_value;
      logic [31:0] min_value;
      logic [31:0] median_value;
      logic [31:0] p95_value;
      logic [31:0] p99_value;
      logic [31:0] max_value;
      logic        overflowed;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_CAND,
      S_SCAN,
      S_WAIT,
      S_CHECK,
      S_DIV,
      S_FINISH,
      S_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic store;
      logic rd_cand;
      logic latch_cand;
      logic rd_scan;
      logic check;
      logic div_start;
      logic div_step;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic scan_last;
      logic cand_last;
      logic div_last;
   } status_type;

endpackage

// ===== sv/dps_ram.sv =====
`timescale 1ns / 1ps
module dps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/dps_ctrl.sv =====
`timescale 1ns / 1ps
module dps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_op,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dps_pkg::cmd_type    cmd,
   input  dps_pkg::status_type status
);
   import dps_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_op == OP_ADD) begin
                  cmd.store = 1'b1;
               end else begin
                  state_in = status.empty ? S_FINISH : S_LOAD;
               end
            end
         end
         S_LOAD: begin
            cmd.rd_cand = 1'b1;
            state_in    = S_CAND;
         end
         S_CAND: begin
            cmd.latch_cand = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            cmd.rd_scan = 1'b1;
            if (status.scan_last) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (status.cand_last) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_LOAD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/dps_datapath.sv =====
`timescale 1ns / 1ps
module dps_datapath #(
   parameter int MAX_SAMPLES = dps_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = dps_pkg::SAMPLE_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  dps_pkg::req_type    req_data,
   input  dps_pkg::cmd_type    cmd,
   output dps_pkg::status_type status,
   output dps_pkg::rsp_type    rsp_data
);
   import dps_pkg::*;

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int SUM_W = SAMPLE_BITS + CNT_W;
   localparam int DC_W  = $clog2(SUM_W);

   logic [CNT_W-1:0]       count_ff, q95_ff, q99_ff, i_ff, j_ff, lt_ff, eq_ff, rem_ff;
   logic [SUM_W-1:0]       sum_ff, quo_ff;
   logic [6:0]             r95_ff, r99_ff;
   logic                   drop_ff, cmp_v_ff;
   logic [SAMPLE_BITS-1:0] cand_ff, min_ff, med_ff, p95_ff, p99_ff, max_ff;
   logic [DC_W-1:0]        dcnt_ff;
   rsp_type                rsp_ff;

   logic [SAMPLE_BITS-1:0] value, rd_data;
   logic [AW-1:0]          rd_addr;
   logic                   full, wr_en;
   logic [7:0]             r95_sum, r99_sum;
   logic [CNT_W-1:0]       last_idx, lt_eq;
   logic [CNT_W:0]         div_sh;
   logic                   div_ge;

   assign value    = SAMPLE_BITS'(req_data.sample);
   assign full     = (count_ff == CNT_W'(MAX_SAMPLES));
   assign wr_en    = cmd.store && !full;
   assign rd_addr  = cmd.rd_cand ? i_ff[AW-1:0] : j_ff[AW-1:0];
   assign last_idx = count_ff - CNT_W'(1);
   assign lt_eq    = lt_ff + eq_ff;
   assign r95_sum  = {1'b0, r95_ff} + 8'd95;
   assign r99_sum  = {1'b0, r99_ff} + 8'd99;
   assign div_sh   = {rem_ff, quo_ff[SUM_W-1]};
   assign div_ge   = (div_sh >= {1'b0, count_ff});

   dps_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[AW-1:0]),
      .wr_data(value),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // rank r falls on the candidate when lt <= r < lt + eq
   function automatic logic hit(input logic [CNT_W-1:0] r, input logic [CNT_W-1:0] lt,
                                input logic [CNT_W-1:0] lte);
      return (lt <= r) && (r < lte);
   endfunction

   // set state: count, sum, running percentile ranks, drop flag
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         count_ff <= '0;
         sum_ff   <= '0;
         drop_ff  <= 1'b0;
         q95_ff   <= '0;
         q99_ff   <= '0;
         r95_ff   <= '0;
         r99_ff   <= '0;
      end else if (wr_en) begin
         count_ff <= count_ff + CNT_W'(1);
         sum_ff   <= sum_ff + SUM_W'(value);
         // floor(n*k/100) tracked incrementally, one subtract per add
         if (r95_sum >= 8'd100) begin
            r95_ff <= 7'(r95_sum - 8'd100);
            q95_ff <= q95_ff + CNT_W'(1);
         end else begin
            r95_ff <= r95_sum[6:0];
         end
         if (r99_sum >= 8'd100) begin
            r99_ff <= 7'(r99_sum - 8'd100);
            q99_ff <= q99_ff + CNT_W'(1);
         end else begin
            r99_ff <= r99_sum[6:0];
         end
      end else if (cmd.store) begin
         drop_ff <= 1'b1;
      end
   end

   // candidate and scan counters
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         i_ff     <= '0;
         j_ff     <= '0;
         cmp_v_ff <= 1'b0;
      end else begin
         cmp_v_ff <= cmd.rd_scan;
         if (cmd.latch_cand) begin
            j_ff <= '0;
         end else if (cmd.rd_scan) begin
            j_ff <= j_ff + CNT_W'(1);
         end
         if (cmd.check) begin
            i_ff <= i_ff + CNT_W'(1);
         end
      end
   end

   // count samples below and equal to the candidate
   always_ff @(posedge clock) begin
      if (cmd.latch_cand) begin
         cand_ff <= rd_data;
         lt_ff   <= '0;
         eq_ff   <= '0;
      end else if (cmp_v_ff) begin
         if (rd_data < cand_ff) begin
            lt_ff <= lt_ff + CNT_W'(1);
         end else if (rd_data == cand_ff) begin
            eq_ff <= eq_ff + CNT_W'(1);
         end
      end
   end

   // capture the order statistics
   always_ff @(posedge clock) begin
      if (cmd.check) begin
         if (hit('0, lt_ff, lt_eq))                     min_ff <= cand_ff;
         if (hit(count_ff >> 1, lt_ff, lt_eq))          med_ff <= cand_ff;
         if (hit(q95_ff, lt_ff, lt_eq))                 p95_ff <= cand_ff;
         if (hit(q99_ff, lt_ff, lt_eq))                 p99_ff <= cand_ff;
         if (hit(last_idx, lt_ff, lt_eq))               max_ff <= cand_ff;
      end
   end

   // restoring divider for the mean, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff  <= sum_ff;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff  <= {quo_ff[SUM_W-2:0], div_ge};
         rem_ff  <= div_ge ? CNT_W'(div_sh - {1'b0, count_ff}) : div_sh[CNT_W-1:0];
         dcnt_ff <= dcnt_ff + DC_W'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (count_ff == '0) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.sample_total <= 11'(count_ff);
            rsp_ff.mean_value   <= 32'(quo_ff);
            rsp_ff.min_value    <= 32'(min_ff);
            rsp_ff.median_value <= 32'(med_ff);
            rsp_ff.p95_value    <= 32'(p95_ff);
            rsp_ff.p99_value    <= 32'(p99_ff);
            rsp_ff.max_value    <= 32'(max_ff);
            rsp_ff.overflowed   <= drop_ff;
         end
      end
   end

   assign rsp_data         = rsp_ff;
   assign status.empty     = (count_ff == '0);
   assign status.scan_last = (j_ff == last_idx);
   assign status.cand_last = (i_ff == last_idx);
   assign status.div_last  = (dcnt_ff == DC_W'(SUM_W - 1));

endmodule

// ===== sv/duration_percentile_statistics.sv =====
// Collects duration samples and, on a finish beat, returns count, floor mean,
// min, median, p95, p99 and max, then clears the set. An add beat is stored
// straight from idle; samples past capacity are dropped and flagged. On a
// finish beat each stored sample in turn is ranked by a full scan of the store
// through its single read port, then a one-bit-per-cycle divider forms the
// mean. An empty set skips both. No input beat is taken while a result waits.
`timescale 1ns / 1ps
module duration_percentile_statistics #(
   parameter int MAX_SAMPLES = dps_pkg::MAX_SAMPLES_DEF,
   parameter int SAMPLE_BITS = dps_pkg::SAMPLE_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dps_pkg::rsp_type rsp_data
);
   import dps_pkg::*;

   cmd_type    cmd;
   status_type status;

   dps_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_op   (req_data.operation),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .status   (status)
   );

   dps_datapath #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_data(req_data),
      .cmd     (cmd),
      .status  (status),
      .rsp_data(rsp_data)
   );

endmodule

// ===== sv/dps_checker.sv =====
`timescale 1ns / 1ps
module dps_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input dps_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input dps_pkg::rsp_type rsp_data
);
   import dps_pkg::*;

   // a stalled input beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("input beat changed under stall");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed under stall");

   // no input beat taken while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted while result pending");

   // empty set reports all zeros
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.sample_total == '0 |-> rsp_data == '0)
      else $error("empty result not zero");

   // order statistics are sorted
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.min_value <= rsp_data.median_value &&
                    rsp_data.median_value <= rsp_data.p95_value &&
                    rsp_data.p95_value <= rsp_data.p99_value &&
                    rsp_data.p99_value <= rsp_data.max_value)
      else $error("percentiles out of order");

endmodule

bind duration_percentile_statistics dps_checker u_dps_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

// ===== sim/tb_duration_percentile_statistics.sv =====
`timescale 1ns / 1ps
module tb_duration_percentile_statistics;
   import dps_pkg::*;

   localparam int CAP = 1024;
   localparam longint CYCLE_LIMIT = 64'd40_000_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   duration_percentile_statistics u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the sample set
   logic [31:0] shadow_set[$];
   logic [41:0] shadow_sum;
   logic        shadow_drop;
   rsp_type     stats_due[$];
   int          mismatches = 0;
   longint      cycles = 0;
   bit          calm = 1'b0;

   task automatic report_mismatch(input string what, input logic [41:0] got,
                                  input logic [41:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic int clamp_rank(int n, int pct);
      int r;
      r = (n * pct) / 100;
      return (r > n - 1) ? n - 1 : r;
   endfunction

   // models one accepted request beat
   task automatic predict_stats(input req_type beat);
      rsp_type     r;
      logic [31:0] sorted[$];
      int          n;
      r = '0;
      if (beat.operation == OP_ADD) begin
         if (shadow_set.size() < CAP) begin
            shadow_set.insert(shadow_set.size(), beat.sample);
            shadow_sum += 42'(beat.sample);
         end else begin
            shadow_drop = 1'b1;
         end
         return;
      end
      n = shadow_set.size();
      if (n > 0) begin
         sorted = shadow_set;
         sorted.sort();
         r.sample_total = n[10:0];
         r.mean_value   = 32'(shadow_sum / n);
         r.min_value    = sorted[0];
         r.median_value = sorted[clamp_rank(n, 50)];
         r.p95_value    = sorted[clamp_rank(n, 95)];
         r.p99_value    = sorted[clamp_rank(n, 99)];
         r.max_value    = sorted[n - 1];
         r.overflowed   = shadow_drop;
      end
      stats_due.insert(stats_due.size(), r);
      shadow_set.delete();
      shadow_sum  = '0;
      shadow_drop = 1'b0;
   endtask

   // result side: random stall and field compare
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (stats_due.size() == 0) begin
               report_mismatch("unexpected beat", 42'(0), 42'(0));
            end else begin
               rsp_type w;
               w = stats_due.pop_front();
               if (rsp_data.sample_total !== w.sample_total)
                  report_mismatch("sample_total", 42'(rsp_data.sample_total),
                                  42'(w.sample_total));
               if (rsp_data.mean_value !== w.mean_value)
                  report_mismatch("mean_value", 42'(rsp_data.mean_value),
                                  42'(w.mean_value));
               if (rsp_data.min_value !== w.min_value)
                  report_mismatch("min_value", 42'(rsp_data.min_value),
                                  42'(w.min_value));
               if (rsp_data.median_value !== w.median_value)
                  report_mismatch("median_value", 42'(rsp_data.median_value),
                                  42'(w.median_value));
               if (rsp_data.p95_value !== w.p95_value)
                  report_mismatch("p95_value", 42'(rsp_data.p95_value),
                                  42'(w.p95_value));
               if (rsp_data.p99_value !== w.p99_value)
                  report_mismatch("p99_value", 42'(rsp_data.p99_value),
                                  42'(w.p99_value));
               if (rsp_data.max_value !== w.max_value)
                  report_mismatch("max_value", 42'(rsp_data.max_value),
                                  42'(w.max_value));
               if (rsp_data.overflowed !== w.overflowed)
                  report_mismatch("overflowed", 42'(rsp_data.overflowed),
                                  42'(w.overflowed));
            end
         end
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 21);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("duration_percentile_statistics regression: fail");
         $finish;
      end
   end

   // sends one beat, with a random idle gap first; waits for acceptance
   task automatic send_beat(input req_type beat);
      while (!calm && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      predict_stats(beat);
   endtask

   function automatic req_type mk(input logic op, input logic [31:0] s);
      req_type b;
      b.operation = op;
      b.sample    = s;
      return b;
   endfunction

   // directed table; fixed expectations are checked beside the predictor
   typedef struct {
      logic        op;
      logic [31:0] smp;
      bit          fixed;
      rsp_type     want;
   } step_row;

   step_row plan[$];

   function automatic rsp_type one_value(input logic [31:0] v);
      rsp_type r;
      r = '0;
      r.sample_total = 11'd1;
      r.mean_value = v; r.min_value = v; r.median_value = v;
      r.p95_value = v; r.p99_value = v; r.max_value = v;
      return r;
   endfunction

   initial begin
      req_type b;
      int      len;
      int      kind;
      int      lim;
      shadow_sum  = '0;
      shadow_drop = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty after reset, single extremes, a small mixed set
      plan.insert(plan.size(), '{OP_FINISH, 32'h0, 1'b1, '0});
      plan.insert(plan.size(), '{OP_ADD, 32'hFFFF_FFFF, 1'b0, '0});
      plan.insert(plan.size(), '{OP_FINISH, 32'h0, 1'b1, one_value(32'hFFFF_FFFF)});
      plan.insert(plan.size(), '{OP_ADD, 32'h0, 1'b0, '0});
      plan.insert(plan.size(), '{OP_FINISH, 32'hFFFF_FFFF, 1'b1, one_value(32'h0)});
      plan.insert(plan.size(), '{OP_FINISH, 32'h1234, 1'b1, '0});
      plan.insert(plan.size(), '{OP_ADD, 32'hFFFF_FFFF, 1'b0, '0});
      plan.insert(plan.size(), '{OP_ADD, 32'hFFFF_FFFF, 1'b0, '0});
      plan.insert(plan.size(), '{OP_ADD, 32'h0000_0005, 1'b0, '0});
      plan.insert(plan.size(), '{OP_ADD, 32'h8000_0000, 1'b0, '0});
      plan.insert(plan.size(), '{OP_ADD, 32'h0, 1'b0, '0});
      plan.insert(plan.size(), '{OP_FINISH, 32'h0, 1'b0, '0});
      plan.insert(plan.size(), '{OP_ADD, 32'h5555_5555, 1'b0, '0});
      plan.insert(plan.size(), '{OP_ADD, 32'hAAAA_AAAA, 1'b0, '0});
      plan.insert(plan.size(), '{OP_FINISH, 32'h0, 1'b0, '0});
      foreach (plan[i]) begin
         if (plan[i].fixed && plan[i].op == OP_FINISH) begin
            rsp_type got;
            send_beat(mk(plan[i].op, plan[i].smp));
            got = stats_due[stats_due.size() - 1];
            if (got !== plan[i].want) report_mismatch("table row", 42'(i), 42'(0));
         end else begin
            send_beat(mk(plan[i].op, plan[i].smp));
         end
      end

      // random sets, mostly small; quiet stretch in the middle
      len = 0;
      while (len < 785) begin
         int n;
         calm = (len > 350 && len < 450);
         kind = $urandom_range(9);
         n = (kind == 0) ? $urandom_range(60, 120) : $urandom_range(0, 20);
         lim = $urandom_range(2) == 0 ? 32'h0000_00FF : 32'hFFFF_FFFF;
         for (int k = 0; k < n; k++) begin
            send_beat(mk(OP_ADD, $urandom & lim));
            len++;
         end
         send_beat(mk(OP_FINISH, $urandom));
         len++;
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      // drain
      while (stats_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatches == 0)
         $display("duration_percentile_statistics regression: pass");
      else
         $display("duration_percentile_statistics regression: fail");
      $finish;
   end

endmodule
